// ===== design/kth_alternating_permutation_unit_defines.svh =====
// Assertion macros shared by the alternating permutation unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef KTH_ALTERNATING_PERMUTATION_UNIT_DEFINES_SVH
`define KTH_ALTERNATING_PERMUTATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KAP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KAP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kap_pkg.sv =====
// Shared types, constants and helpers for the alternating permutation unit.
// No dependencies.
`default_nettype none

package kap_pkg;

    localparam int MAX_LEN   = 20;
    localparam int LEN_W     = 5;
    localparam int RANK_W    = 50;
    // count table: (first-rank, length, direction), ranks and lengths 1..MAX_LEN
    localparam int TBL_DEPTH = MAX_LEN * MAX_LEN * 2;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [MAX_LEN-1:0] t_used;

    typedef struct packed {
        logic valid;
        t_len value;
        logic last;
        logic rank_error;
    } t_emit;

    // row-major: length, then first-rank, then direction
    function automatic t_addr tbl_addr(input t_len r, input t_len l, input logic d);
        t_addr lm;
        t_addr rm;
        lm = t_addr'(t_len'(l - t_len'(1)));
        rm = t_addr'(t_len'(r - t_len'(1)));
        return t_addr'(lm * t_addr'(2 * MAX_LEN)) + t_addr'(rm << 1) + t_addr'(d);
    endfunction

endpackage

`default_nettype wire

// ===== design/kap_if.sv =====
// Request and result channel interfaces of the alternating permutation unit.
// Depends on kap_pkg.
`default_nettype none

interface kap_req_if;
    logic          valid;
    logic          ready;
    kap_pkg::t_len  perm_length;
    kap_pkg::t_rank rank;

    modport source (output valid, output perm_length, output rank, input ready);
    modport sink   (input valid, input perm_length, input rank, output ready);
endinterface

interface kap_res_if;
    logic         valid;
    logic         ready;
    kap_pkg::t_len value;
    logic         last;
    logic         rank_error;

    modport source (output valid, output value, output last, output rank_error, input ready);
    modport sink   (input valid, input value, input last, input rank_error, output ready);
endinterface

`default_nettype wire

// ===== design/kap_count_mem.sv =====
// Count table storage: one write port, one read port with registered data.
// Depends on kap_pkg.
`default_nettype none

module kap_count_mem (
    input  logic           i_clk,
    input  logic           i_we,
    input  kap_pkg::t_addr i_waddr,
    input  kap_pkg::t_rank i_wdata,
    input  kap_pkg::t_addr i_raddr,
    output kap_pkg::t_rank o_rdata
);
    import kap_pkg::*;

    t_rank r_mem [TBL_DEPTH];
    t_rank r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/kap_alu.sv =====
// Shared 50-bit add/subtract unit; in subtract mode also flags a - b <= 0.
// Depends on kap_pkg.
`default_nettype none

module kap_alu (
    input  kap_pkg::t_rank i_a,
    input  kap_pkg::t_rank i_b,
    input  logic           i_sub,
    output kap_pkg::t_rank o_res,
    output logic           o_fits
);
    import kap_pkg::*;

    logic [RANK_W:0] sum;

    // subtract as a + ~b + 1; top bit set means no borrow (a >= b)
    assign sum    = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (RANK_W + 1)'(i_sub);
    assign o_res  = sum[RANK_W-1:0];
    assign o_fits = !sum[RANK_W] || (sum[RANK_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== design/kap_engine.sv =====
// Sequencer: builds the count table after reset, then unranks one request at a
// time using the table memory and the shared subtractor. Depends on kap_pkg,
// kap_if, kap_count_mem, kap_alu and the assertion macro header.
`default_nettype none
`include "kth_alternating_permutation_unit_defines.svh"

module kap_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kap_req_if.sink        i_req,
    input  logic           i_out_free,
    output kap_pkg::t_emit o_emit
);
    import kap_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_B_INIT0  = 4'd0;
    localparam logic [ST_W-1:0] ST_B_INIT1  = 4'd1;
    localparam logic [ST_W-1:0] ST_B_SUMRD  = 4'd2;
    localparam logic [ST_W-1:0] ST_B_SUMADD = 4'd3;
    localparam logic [ST_W-1:0] ST_B_WR0    = 4'd4;
    localparam logic [ST_W-1:0] ST_B_WR1    = 4'd5;
    localparam logic [ST_W-1:0] ST_B_ADD0   = 4'd6;
    localparam logic [ST_W-1:0] ST_B_SUB1   = 4'd7;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd8;
    localparam logic [ST_W-1:0] ST_F_RD     = 4'd9;
    localparam logic [ST_W-1:0] ST_F_A      = 4'd10;
    localparam logic [ST_W-1:0] ST_F_B      = 4'd11;
    localparam logic [ST_W-1:0] ST_S_SCAN   = 4'd12;
    localparam logic [ST_W-1:0] ST_S_CMP    = 4'd13;
    localparam logic [ST_W-1:0] ST_EMIT     = 4'd14;

    logic [ST_W-1:0] r_state, n_state;
    t_len  r_n,     n_n;
    t_len  r_len,   n_len;
    t_len  r_j,     n_j;
    t_len  r_cnt,   n_cnt;
    t_len  r_prev,  n_prev;
    t_len  r_bprev, n_bprev;
    t_len  r_val,   n_val;
    t_used r_used,  n_used;
    logic  r_multi, n_multi;
    logic  r_last,  n_last;
    logic  r_err,   n_err;
    // during the build r_rem holds the "up" running sum and r_tmp the "down" one
    t_rank r_rem,   n_rem;
    t_rank r_tmp,   n_tmp;

    logic  mem_we;
    t_addr mem_waddr;
    t_rank mem_wdata;
    t_addr mem_raddr;
    t_rank mem_rdata;

    t_rank alu_a;
    logic  alu_sub;
    t_rank alu_res;
    logic  alu_fits;

    logic  cand_dir;
    logic  went_up;
    logic  skip;
    t_len  j_idx;
    t_len  j_inc;
    t_len  cnt_inc;
    t_used j_bit;

    kap_count_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    kap_alu u_alu (
        .i_a    (alu_a),
        .i_b    (mem_rdata),
        .i_sub  (alu_sub),
        .o_res  (alu_res),
        .o_fits (alu_fits)
    );

    assign cand_dir = (r_j > r_prev);
    assign went_up  = (r_prev > r_bprev);
    // after two elements the next step must reverse direction
    assign skip     = r_multi && (went_up == cand_dir);
    assign j_idx    = r_j - t_len'(1);
    assign j_inc    = r_j + t_len'(1);
    assign cnt_inc  = r_cnt + t_len'(1);
    assign j_bit    = t_used'(1) << j_idx;

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_len     = r_len;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_bprev   = r_bprev;
        n_val     = r_val;
        n_used    = r_used;
        n_multi   = r_multi;
        n_last    = r_last;
        n_err     = r_err;
        n_rem     = r_rem;
        n_tmp     = r_tmp;
        mem_we    = 1'b0;
        mem_waddr = tbl_addr(r_j, r_len, 1'b0);
        mem_wdata = r_rem;
        mem_raddr = tbl_addr(r_j, r_len, 1'b0);
        alu_a     = r_rem;
        alu_sub   = 1'b1;
        o_emit.valid      = 1'b0;
        o_emit.value      = r_val;
        o_emit.last       = r_last;
        o_emit.rank_error = r_err;

        case (r_state)
            ST_B_INIT0: begin
                mem_we    = 1'b1;
                mem_waddr = tbl_addr(t_len'(1), t_len'(1), 1'b0);
                mem_wdata = t_rank'(1);
                n_state   = ST_B_INIT1;
            end
            ST_B_INIT1: begin
                mem_we    = 1'b1;
                mem_waddr = tbl_addr(t_len'(1), t_len'(1), 1'b1);
                mem_wdata = t_rank'(1);
                n_len     = t_len'(2);
                n_j       = t_len'(1);
                n_rem     = '0;
                n_tmp     = '0;
                n_state   = (MAX_LEN == 1) ? ST_IDLE : ST_B_SUMRD;
            end
            ST_B_SUMRD: begin
                mem_raddr = tbl_addr(r_j, r_len - t_len'(1), 1'b1);
                n_state   = ST_B_SUMADD;
            end
            ST_B_SUMADD: begin
                alu_sub = 1'b0;
                n_rem   = alu_res;
                if (r_j == r_len - t_len'(1)) begin
                    n_j     = t_len'(1);
                    n_state = ST_B_WR0;
                end else begin
                    n_j     = j_inc;
                    n_state = ST_B_SUMRD;
                end
            end
            ST_B_WR0: begin
                mem_we    = 1'b1;
                mem_waddr = tbl_addr(r_j, r_len, 1'b0);
                mem_wdata = r_rem;
                n_state   = ST_B_WR1;
            end
            ST_B_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = tbl_addr(r_j, r_len, 1'b1);
                mem_wdata = r_tmp;
                mem_raddr = tbl_addr(r_j, r_len - t_len'(1), 1'b0);
                if (r_j == r_len) begin
                    if (r_len == t_len'(MAX_LEN)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_len   = r_len + t_len'(1);
                        n_j     = t_len'(1);
                        n_rem   = '0;
                        n_tmp   = '0;
                        n_state = ST_B_SUMRD;
                    end
                end else begin
                    n_state = ST_B_ADD0;
                end
            end
            ST_B_ADD0: begin
                alu_a     = r_tmp;
                alu_sub   = 1'b0;
                n_tmp     = alu_res;
                mem_raddr = tbl_addr(r_j, r_len - t_len'(1), 1'b1);
                n_state   = ST_B_SUB1;
            end
            ST_B_SUB1: begin
                n_rem   = alu_res;
                n_j     = j_inc;
                n_state = ST_B_WR0;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_n     = i_req.perm_length;
                    n_rem   = i_req.rank;
                    n_used  = '0;
                    n_prev  = '0;
                    n_bprev = '0;
                    n_multi = 1'b0;
                    n_j     = t_len'(1);
                    n_cnt   = '0;
                    n_val   = '0;
                    n_last  = 1'b0;
                    n_err   = 1'b0;
                    if ((i_req.perm_length == '0) ||
                        (i_req.perm_length > t_len'(MAX_LEN)) ||
                        (i_req.rank == '0)) begin
                        n_err   = 1'b1;
                        n_last  = 1'b1;
                        n_state = ST_EMIT;
                    end else if (i_req.perm_length == t_len'(1)) begin
                        n_last  = 1'b1;
                        if (i_req.rank == t_rank'(1)) begin
                            n_val = t_len'(1);
                        end else begin
                            n_err = 1'b1;
                        end
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_F_RD;
                    end
                end
            end
            // first element: count of either direction, taken in two subtractions
            ST_F_RD: begin
                mem_raddr = tbl_addr(r_j, r_n, 1'b0);
                n_state   = ST_F_A;
            end
            ST_F_A: begin
                mem_raddr = tbl_addr(r_j, r_n, 1'b1);
                if (alu_fits) begin
                    n_used  = r_used | j_bit;
                    n_prev  = r_j;
                    n_val   = r_j;
                    n_len   = r_n - t_len'(1);
                    n_j     = t_len'(1);
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_tmp   = alu_res;
                    n_state = ST_F_B;
                end
            end
            ST_F_B: begin
                alu_a = r_tmp;
                if (alu_fits) begin
                    n_used  = r_used | j_bit;
                    n_prev  = r_j;
                    n_val   = r_j;
                    n_len   = r_n - t_len'(1);
                    n_j     = t_len'(1);
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else if (r_j == r_n) begin
                    // rank beyond the total count
                    n_val   = '0;
                    n_err   = 1'b1;
                    n_last  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_rem   = alu_res;
                    n_j     = j_inc;
                    n_state = ST_F_RD;
                end
            end
            ST_S_SCAN: begin
                if (r_j > r_n) begin
                    n_state = ST_IDLE;
                end else if (r_used[j_idx]) begin
                    n_j = j_inc;
                end else begin
                    n_cnt = cnt_inc;
                    if (skip) begin
                        n_j = j_inc;
                    end else begin
                        mem_raddr = tbl_addr(cnt_inc, r_len, cand_dir);
                        n_state   = ST_S_CMP;
                    end
                end
            end
            ST_S_CMP: begin
                if (alu_fits) begin
                    n_used  = r_used | j_bit;
                    n_bprev = r_prev;
                    n_prev  = r_j;
                    n_val   = r_j;
                    n_last  = (r_len == t_len'(1));
                    n_multi = 1'b1;
                    n_len   = r_len - t_len'(1);
                    n_j     = t_len'(1);
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_rem   = alu_res;
                    n_j     = j_inc;
                    n_state = ST_S_SCAN;
                end
            end
            ST_EMIT: begin
                o_emit.valid = 1'b1;
                if (i_out_free) begin
                    n_state = r_last ? ST_IDLE : ST_S_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_B_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_len   <= n_len;
        r_j     <= n_j;
        r_cnt   <= n_cnt;
        r_prev  <= n_prev;
        r_bprev <= n_bprev;
        r_val   <= n_val;
        r_used  <= n_used;
        r_multi <= n_multi;
        r_last  <= n_last;
        r_err   <= n_err;
        r_rem   <= n_rem;
        r_tmp   <= n_tmp;
    end

    `KAP_ASSERT_IMPL(a_err_item, i_clk, i_rst_n, o_emit.valid && o_emit.rank_error, o_emit.last && (o_emit.value == '0), "error item must be a single last item with value zero")
    `KAP_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, r_state == ST_S_SCAN, r_cnt <= r_len, "candidate count ran past the remaining length")
    `KAP_ASSERT_IMPL(a_used_len, i_clk, i_rst_n, (r_state == ST_S_SCAN) || (r_state == ST_S_CMP), $countones(r_used) == int'(r_n - r_len), "used mask out of step with remaining length")
    `KAP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != ST_IDLE, "sequencer still idle after accepting an item")

endmodule

`default_nettype wire

// ===== design/kth_alternating_permutation_unit.sv =====
// channel | dir | fields                           | item
// i_req   | in  | perm_length[4:0], rank[49:0]     | one request
// o_res   | out | value[4:0], last, rank_error     | one permutation element
//
// After reset the count table is built; i_req.ready stays low until then.
// A request: it is accepted, the first element is found by trying each value in turn with two
// table lookups and subtractions, then each later position skips used or non-alternating
// values and does a table lookup for each other one, and each element is emitted; the pace is
// set by the single table read port and shared subtractor, and o_res.ready can stall emission.
// Reset is synchronous, active low. Results go through an output register, so the next
// request is taken while the last element still waits on o_res.ready.
// Depends on kap_pkg, kap_if and kap_engine.
`default_nettype none

module kth_alternating_permutation_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kap_req_if.sink    i_req,
    kap_res_if.source  o_res
);
    import kap_pkg::*;

    t_emit emit;
    logic  out_free;
    logic  r_out_valid;
    t_len  r_value;
    logic  r_last;
    logic  r_err;

    assign out_free = !r_out_valid || o_res.ready;

    kap_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid && out_free) begin
            r_value <= emit.value;
            r_last  <= emit.last;
            r_err   <= emit.rank_error;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_value;
    assign o_res.last       = r_last;
    assign o_res.rank_error = r_err;

endmodule

`default_nettype wire
